// ===== src/crt_pkg.sv =====
// Shared types, constants and weight function for the Catmull-Rom tessellator.
// No dependencies; every other file of the block imports this package.
package crt_pkg;

    // Fixed width of the incoming coordinate ports.
    localparam int POINT_BITS  = 16;
    // Quotient bits of the fixed-point divide (offset range of one sample).
    localparam int QUOT_BITS   = POINT_BITS + 2;
    // Register stages from the latched operands to the sample result.
    localparam int EVAL_STAGES = 7;
    // Default configuration handed to the top-level parameters.
    localparam int SAMPLES_DEF = 16;
    localparam int COORD_DEF   = 16;
    // Entries of the job queue between front and back.
    localparam int JOB_DEPTH   = 4;

    // One segment (or the start point) to be sampled by the back end.
    typedef struct packed {
        logic [3:0][POINT_BITS-1:0] px;
        logic [3:0][POINT_BITS-1:0] py;
        logic                       start_only;
        logic                       run_last;
    } job_t;

    // Push strobes from the front into the job queue.
    typedef struct packed {
        logic push0;
        logic push1;
    } job_push_t;

    // Integer Catmull-Rom weight of control point j at sample s of n,
    // scaled by 2*n^3.
    function automatic longint crt_weight(input int j, input int s, input int n);
        longint ls;
        longint ln;
        longint w;
        ls = longint'(s);
        ln = longint'(n);
        case (j)
            0:       w = -ls * ln * ln + 2 * ls * ls * ln - ls * ls * ls;
            1:       w = 2 * ln * ln * ln - 5 * ls * ls * ln + 3 * ls * ls * ls;
            2:       w = ls * ln * ln + 4 * ls * ls * ln - 3 * ls * ls * ls;
            default: w = -ls * ls * ln + ls * ls * ls;
        endcase
        return w;
    endfunction

endpackage

// ===== src/crt_front.sv =====
// Front end: accepts control points, keeps the point window and count,
// and turns each point into zero, one or two jobs. Depends on crt_pkg.
module crt_front #(
    parameter int COORD_BITS = crt_pkg::COORD_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic                                 full,
    input  logic [crt_pkg::POINT_BITS-1:0]       point_x,
    input  logic [crt_pkg::POINT_BITS-1:0]       point_y,
    input  logic                                 last_point,
    output crt_pkg::job_push_t                   job_push,
    output crt_pkg::job_t                        job0,
    output crt_pkg::job_t                        job1
);
    import crt_pkg::*;

    localparam logic [POINT_BITS-1:0] CMASK =
        POINT_BITS'((64'd1 << COORD_BITS) - 64'd1);

    logic [2:0][POINT_BITS-1:0] wx_reg, wx_next;
    logic [2:0][POINT_BITS-1:0] wy_reg, wy_next;
    logic [1:0]                 seen_reg, seen_next;
    logic                       accept;
    logic [POINT_BITS-1:0]      cur_x, cur_y;
    logic [POINT_BITS-1:0]      first_x, first_y;

    assign accept = push && !full;
    assign cur_x  = point_x & CMASK;
    assign cur_y  = point_y & CMASK;

    // Clamp the missing left neighbor of the first segment.
    assign first_x = (seen_reg == 2'd2) ? wx_reg[1] : wx_reg[0];
    assign first_y = (seen_reg == 2'd2) ? wy_reg[1] : wy_reg[0];

    // Classify the beat and build its jobs
    always_comb
    begin
        job_push = '0;
        job0     = '0;
        job1     = '0;
        if (seen_reg == 2'd1)
        begin
            job0.px         = {wx_reg[2], wx_reg[2], wx_reg[2], wx_reg[2]};
            job0.py         = {wy_reg[2], wy_reg[2], wy_reg[2], wy_reg[2]};
            job0.start_only = 1'b1;
            job0.run_last   = !last_point;
            job1.px         = {cur_x, cur_x, wx_reg[2], wx_reg[2]};
            job1.py         = {cur_y, cur_y, wy_reg[2], wy_reg[2]};
            job1.run_last   = 1'b1;
            job_push.push0  = accept;
            job_push.push1  = accept && last_point;
        end
        else if (seen_reg != 2'd0)
        begin
            job0.px         = {cur_x, wx_reg[2], wx_reg[1], first_x};
            job0.py         = {cur_y, wy_reg[2], wy_reg[1], first_y};
            job0.run_last   = !last_point;
            job1.px         = {cur_x, cur_x, wx_reg[2], wx_reg[1]};
            job1.py         = {cur_y, cur_y, wy_reg[2], wy_reg[1]};
            job1.run_last   = 1'b1;
            job_push.push0  = accept;
            job_push.push1  = accept && last_point;
        end
    end

    // Advance the window, or clear it after the last point
    always_comb
    begin
        wx_next   = wx_reg;
        wy_next   = wy_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            if (last_point)
            begin
                wx_next   = '0;
                wy_next   = '0;
                seen_next = 2'd0;
            end
            else
            begin
                wx_next   = {cur_x, wx_reg[2], wx_reg[1]};
                wy_next   = {cur_y, wy_reg[2], wy_reg[1]};
                seen_next = (seen_reg == 2'd3) ? 2'd3 : seen_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wx_reg   <= '0;
            wy_reg   <= '0;
            seen_reg <= 2'd0;
        end
        else
        begin
            wx_reg   <= wx_next;
            wy_reg   <= wy_next;
            seen_reg <= seen_next;
        end
    end

endmodule

// ===== src/crt_job_fifo.sv =====
// Short job queue between front and back; takes up to two jobs per beat.
// Depends on crt_pkg.
module crt_job_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  crt_pkg::job_push_t job_push,
    input  crt_pkg::job_t      job0,
    input  crt_pkg::job_t      job1,
    output logic               full,
    output crt_pkg::job_t      job,
    output logic               empty,
    input  logic               pop
);
    import crt_pkg::*;

    localparam int JPW = $clog2(JOB_DEPTH);
    localparam int JCW = $clog2(JOB_DEPTH + 1);

    job_t           q_reg [JOB_DEPTH];
    logic [JPW-1:0] wp_reg, wp_next;
    logic [JPW-1:0] rp_reg, rp_next;
    logic [JCW-1:0] cnt_reg, cnt_next;

    // Keep room for the two jobs a last point can make
    assign full  = cnt_reg > JCW'(JOB_DEPTH - 2);
    assign empty = cnt_reg == '0;
    assign job   = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg + JPW'(job_push.push0) + JPW'(job_push.push1);
        rp_next  = rp_reg + JPW'(pop);
        cnt_next = cnt_reg + JCW'(job_push.push0) + JCW'(job_push.push1) - JCW'(pop);
    end

    // Store jobs
    always_ff @(posedge clk)
    begin
        if (job_push.push0)
            q_reg[wp_reg] <= job0;
        if (job_push.push1)
            q_reg[wp_reg + JPW'(1)] <= job1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/crt_eval.sv =====
// Sample datapath for one coordinate: weighted sum, rounding divide by
// 2*S^3 (reciprocal multiply with one correction step) and saturation. Depends on crt_pkg.
module crt_eval #(
    parameter int SPS        = crt_pkg::SAMPLES_DEF,
    parameter int COORD_BITS = crt_pkg::COORD_DEF
) (
    input  logic                                      clk,
    input  logic [3:0][crt_pkg::POINT_BITS-1:0]       pts,
    input  logic signed [$clog2(2*SPS*SPS*SPS)+1:0]   wts [4],
    output logic signed [COORD_BITS+1:0]              result
);
    import crt_pkg::*;

    localparam longint DENOM = longint'(2) * SPS * SPS * SPS;
    localparam int     WB    = $clog2(2 * SPS * SPS * SPS) + 2;
    localparam int     DB    = $clog2(DENOM + 1);
    localparam int     QB    = QUOT_BITS;
    localparam int     XW    = QB + DB;
    localparam int     MW    = QB + 2;
    localparam int     PRW   = WB + POINT_BITS + 1;
    localparam int     NW    = PRW + 2;
    localparam longint OFF   = longint'(1) << (POINT_BITS + 1);
    localparam longint BIAS  = DENOM / 2 + OFF * DENOM;
    // Scaled reciprocal of the divisor; its quotient estimate is low by at most one
    localparam longint RECIP = (longint'(1) << XW) / DENOM;
    localparam int     SATW  = (QB + 1 > COORD_BITS + 3) ? QB + 1 : COORD_BITS + 3;
    localparam logic signed [SATW-1:0] SAT_LO =
        SATW'(-(longint'(1) << (COORD_BITS - 1)));
    localparam logic signed [SATW-1:0] SAT_HI =
        SATW'(3 * (longint'(1) << (COORD_BITS - 1)) - 1);

    logic signed [PRW-1:0]  prod_reg [4];
    logic signed [NW-1:0]   sum_c;
    logic [XW-1:0]          num_reg;
    logic [XW+MW-1:0]       mq_reg;
    logic [XW-1:0]          n1_reg;
    logic [QB-1:0]          qe_reg;
    logic [XW-1:0]          n2_reg;
    logic [XW-1:0]          qd_reg;
    logic [QB-1:0]          qe2_reg;
    logic [XW-1:0]          n3_reg;
    logic [XW-1:0]          r_c;
    logic [QB-1:0]          quo_reg;
    logic signed [SATW-1:0] qs_c;
    logic signed [SATW-1:0] sat_c;

    // Multiply each point by its weight
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
            prod_reg[j] <= $signed({1'b0, pts[j]}) * wts[j];
    end

    // Sum and offset so the dividend is never negative
    assign sum_c = NW'(prod_reg[0]) + NW'(prod_reg[1]) + NW'(prod_reg[2])
                 + NW'(prod_reg[3]) + NW'(BIAS);

    // Estimate the quotient, then check it against the divisor
    always_ff @(posedge clk)
    begin
        num_reg <= sum_c[XW-1:0];
        mq_reg  <= (XW+MW)'(num_reg) * (XW+MW)'(RECIP);
        n1_reg  <= num_reg;
        qe_reg  <= mq_reg[XW +: QB];
        n2_reg  <= n1_reg;
        qd_reg  <= XW'(qe_reg) * XW'(DENOM);
        qe2_reg <= qe_reg;
        n3_reg  <= n2_reg;
    end

    // Bump the estimate when a whole divisor is left over
    assign r_c = n3_reg - qd_reg;

    always_ff @(posedge clk)
    begin
        quo_reg <= qe2_reg + QB'(r_c >= XW'(DENOM));
    end

    // Remove the offset and clamp to the output range
    assign qs_c = SATW'({1'b0, quo_reg}) - SATW'(OFF);

    always_comb
    begin
        if (qs_c < SAT_LO)
            sat_c = SAT_LO;
        else if (qs_c > SAT_HI)
            sat_c = SAT_HI;
        else
            sat_c = qs_c;
    end

    always_ff @(posedge clk)
    begin
        result <= sat_c[COORD_BITS+1:0];
    end

endmodule

// ===== src/crt_back.sv =====
// Back end: steps through the samples of each job, drives the two
// coordinate datapaths and buffers results in the output queue. Depends on crt_pkg, crt_eval.
module crt_back #(
    parameter int SPS        = crt_pkg::SAMPLES_DEF,
    parameter int COORD_BITS = crt_pkg::COORD_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  crt_pkg::job_t                job,
    input  logic                         job_empty,
    output logic                         job_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic signed [COORD_BITS+1:0] curve_x,
    output logic signed [COORD_BITS+1:0] curve_y,
    output logic                         path_start,
    output logic                         run_last
);
    import crt_pkg::*;

    localparam int WB  = $clog2(2 * SPS * SPS * SPS) + 2;
    localparam int SBW = $clog2(SPS + 1);
    localparam int EL  = EVAL_STAGES;
    localparam int OD  = 1 << $clog2(EL + 3);
    localparam int OPW = $clog2(OD);
    localparam int OCW = $clog2(OD + 1);

    typedef struct packed {
        logic valid;
        logic path_start;
        logic run_last;
    } side_t;

    logic signed [WB-1:0]         wtab [SPS+1][4];
    logic                         busy_reg;
    logic [SBW-1:0]               s_reg;
    logic [SBW-1:0]               cur_s;
    logic                         last_sample;
    logic                         credit;
    logic                         issue;
    side_t                        side0_reg;
    side_t                        side_reg [EL];
    logic [3:0][POINT_BITS-1:0]   px0_reg, py0_reg;
    logic signed [WB-1:0]         w0_reg [4];
    logic signed [COORD_BITS+1:0] ex, ey;
    logic                         wr;
    logic                         rd;
    logic signed [COORD_BITS+1:0] ox_mem [OD];
    logic signed [COORD_BITS+1:0] oy_mem [OD];
    logic [OD-1:0]                ops_mem;
    logic [OD-1:0]                orl_mem;
    logic [OPW-1:0]               wp_reg, rp_reg;
    logic [OCW-1:0]               out_cnt_reg, out_cnt_next;
    logic [OCW-1:0]               inflight_reg, inflight_next;

    // Constant weight table, one row per sample index
    for (genvar gs = 0; gs <= SPS; gs++)
    begin : g_row
        for (genvar gj = 0; gj < 4; gj++)
        begin : g_col
            assign wtab[gs][gj] = WB'(crt_weight(gj, gs, SPS));
        end
    end

    // Pick the sample to issue and check output credit
    always_comb
    begin
        cur_s       = busy_reg ? s_reg : (job.start_only ? '0 : SBW'(1));
        last_sample = job.start_only || (cur_s == SBW'(SPS));
        credit      = ({1'b0, out_cnt_reg} + {1'b0, inflight_reg}) < (OCW + 1)'(OD);
        issue       = !job_empty && credit;
        job_pop     = issue && last_sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            s_reg     <= '0;
            side0_reg <= '0;
        end
        else
        begin
            side0_reg.valid      <= issue;
            side0_reg.path_start <= job.start_only;
            side0_reg.run_last   <= job.run_last && last_sample;
            if (issue)
            begin
                busy_reg <= !last_sample;
                s_reg    <= cur_s + SBW'(1);
            end
        end
    end

    // Latch the operands of the issued sample
    always_ff @(posedge clk)
    begin
        px0_reg <= job.px;
        py0_reg <= job.py;
        for (int j = 0; j < 4; j++)
            w0_reg[j] <= wtab[cur_s][j];
    end

    crt_eval #(
        .SPS        (SPS),
        .COORD_BITS (COORD_BITS)
    ) u_eval_x (
        .clk    (clk),
        .pts    (px0_reg),
        .wts    (w0_reg),
        .result (ex)
    );

    crt_eval #(
        .SPS        (SPS),
        .COORD_BITS (COORD_BITS)
    ) u_eval_y (
        .clk    (clk),
        .pts    (py0_reg),
        .wts    (w0_reg),
        .result (ey)
    );

    // Carry sample flags alongside the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < EL; k++)
                side_reg[k] <= '0;
        end
        else
        begin
            side_reg[0] <= side0_reg;
            for (int k = 1; k < EL; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign wr    = side_reg[EL-1].valid;
    assign empty = out_cnt_reg == '0;
    assign rd    = pop && !empty;

    // Output queue storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            ox_mem[wp_reg]  <= ex;
            oy_mem[wp_reg]  <= ey;
            ops_mem[wp_reg] <= side_reg[EL-1].path_start;
            orl_mem[wp_reg] <= side_reg[EL-1].run_last;
        end
    end

    assign curve_x    = ox_mem[rp_reg];
    assign curve_y    = oy_mem[rp_reg];
    assign path_start = ops_mem[rp_reg];
    assign run_last   = orl_mem[rp_reg];

    always_comb
    begin
        out_cnt_next  = out_cnt_reg + OCW'(wr) - OCW'(rd);
        inflight_next = inflight_reg + OCW'(issue) - OCW'(wr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            rp_reg       <= '0;
            out_cnt_reg  <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            wp_reg       <= wp_reg + OPW'(wr);
            rp_reg       <= rp_reg + OPW'(rd);
            out_cnt_reg  <= out_cnt_next;
            inflight_reg <= inflight_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, out_cnt_reg} + {1'b0, inflight_reg}) <= (OCW + 1)'(OD))
        else $error("output queue credit exceeded");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> (out_cnt_reg != OCW'(OD)))
        else $error("sample written into a full output queue");

    a_busy_holds_job: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !job_empty)
        else $error("job queue emptied in the middle of a segment");
`endif

endmodule

// ===== src/catmull_rom_curve_tessellator.sv =====
// Top level of the uniform Catmull-Rom curve tessellator.
// Depends on crt_pkg, crt_front, crt_job_fifo, crt_back.
//
// Control points enter one beat per cycle while full is low, through the
// push/full queue port; the front end turns each point into sampling jobs,
// and the back end produces one sample per cycle while a job is queued and
// output queue credit allows, SAMPLES_PER_SEGMENT results for an ordinary
// point, one for the start point and up to 2*SAMPLES_PER_SEGMENT for the
// last point of a curve. A sample passes through the operand latch and the
// multiply, sum, reciprocal multiply, quotient estimate, estimate check,
// correction and clamp registers before it reaches the result queue. A
// four-entry job queue lets points be taken while a segment is still being
// sampled, and a 16-entry result queue keeps the datapath running while
// results wait for pop. No clearing pass after reset.
module catmull_rom_curve_tessellator #(
    parameter int SAMPLES_PER_SEGMENT = crt_pkg::SAMPLES_DEF,
    parameter int COORD_BITS          = crt_pkg::COORD_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [crt_pkg::POINT_BITS-1:0]    point_x,
    input  logic [crt_pkg::POINT_BITS-1:0]    point_y,
    input  logic                              last_point,
    input  logic                              pop,
    output logic                              empty,
    output logic signed [COORD_BITS+1:0]      curve_x,
    output logic signed [COORD_BITS+1:0]      curve_y,
    output logic                              path_start,
    output logic                              run_last
);
    import crt_pkg::*;

    job_push_t job_push;
    job_t      job0, job1;
    job_t      job;
    logic      job_empty;
    logic      job_pop;

    crt_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point),
        .job_push   (job_push),
        .job0       (job0),
        .job1       (job1)
    );

    crt_job_fifo u_job_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_push (job_push),
        .job0     (job0),
        .job1     (job1),
        .full     (full),
        .job      (job),
        .empty    (job_empty),
        .pop      (job_pop)
    );

    crt_back #(
        .SPS        (SAMPLES_PER_SEGMENT),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (job),
        .job_empty  (job_empty),
        .job_pop    (job_pop),
        .pop        (pop),
        .empty      (empty),
        .curve_x    (curve_x),
        .curve_y    (curve_y),
        .path_start (path_start),
        .run_last   (run_last)
    );

endmodule

// ===== dv/catmull_rom_curve_tessellator_test.sv =====
// Self-checking testbench for the Catmull-Rom curve tessellator: control points
// in, predicted curve samples compared beat by beat on the result port.
// Depends on crt_pkg and catmull_rom_curve_tessellator.
`timescale 1ns / 1ps

module catmull_rom_curve_tessellator_test;

    localparam int SAMPLES    = crt_pkg::SAMPLES_DEF;
    localparam int COORD_BITS = crt_pkg::COORD_DEF;
    localparam int PT_BITS    = crt_pkg::POINT_BITS;
    localparam int OUT_BITS   = COORD_BITS + 2;

    // Traffic shapes, one per part of the run
    localparam int PH_STEADY    = 0;
    localparam int PH_SEND_IDLE = 1;
    localparam int PH_RECV_IDLE = 2;
    localparam int PH_BOTH_IDLE = 3;

    localparam int ITEMS_PER_PHASE = 70;
    localparam int DRAIN_CYCLES    = 100;

    typedef struct {
        logic [PT_BITS-1:0] x;
        logic [PT_BITS-1:0] y;
        logic               last;
        int                 phase;
    } ctrl_point_t;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } pt_t;

    typedef struct {
        logic signed [OUT_BITS-1:0] x;
        logic signed [OUT_BITS-1:0] y;
        logic                       start;
        logic                       run_last;
    } sample_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic [PT_BITS-1:0]         point_x = '0;
    logic [PT_BITS-1:0]         point_y = '0;
    logic                       last_point = 1'b0;
    logic                       pop = 1'b0;
    logic                       empty;
    logic signed [OUT_BITS-1:0] curve_x;
    logic signed [OUT_BITS-1:0] curve_y;
    logic                       path_start;
    logic                       run_last;

    ctrl_point_t points_to_send[$];
    sample_t     expected_samples[$];
    int          error_count = 0;
    int          cur_phase = PH_STEADY;

    // Predictor copy of the point history
    pt_t         hist[3];
    int          hist_count = 0;

    catmull_rom_curve_tessellator #(
        .SAMPLES_PER_SEGMENT(SAMPLES),
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .point_x(point_x),
        .point_y(point_y),
        .last_point(last_point),
        .pop(pop),
        .empty(empty),
        .curve_x(curve_x),
        .curve_y(curve_y),
        .path_start(path_start),
        .run_last(run_last)
    );

    always #1 clk = ~clk;

    // One coordinate of the spline at t = s/SAMPLES, rounded half up, clamped
    function automatic logic signed [OUT_BITS-1:0] spline_value(
        input logic [COORD_BITS-1:0] p0,
        input logic [COORD_BITS-1:0] p1,
        input logic [COORD_BITS-1:0] p2,
        input logic [COORD_BITS-1:0] p3,
        input int                    s
    );
        longint a0, a1, a2, a3;
        longint ns, ls, num, den, q, lo, hi;
        a0 = longint'(p0);
        a1 = longint'(p1);
        a2 = longint'(p2);
        a3 = longint'(p3);
        ns = longint'(SAMPLES);
        ls = longint'(s);
        den = 2 * ns * ns * ns;
        num = 2 * a1 * ns * ns * ns
            + (a2 - a0) * ls * ns * ns
            + (2 * a0 - 5 * a1 + 4 * a2 - a3) * ls * ls * ns
            + (-a0 + 3 * a1 - 3 * a2 + a3) * ls * ls * ls;
        num = num + den / 2;
        q = num / den;
        // floor for negative numerators
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        lo = -(longint'(1) << (COORD_BITS - 1));
        hi = 3 * (longint'(1) << (COORD_BITS - 1)) - 1;
        if (q < lo)
            q = lo;
        if (q > hi)
            q = hi;
        return q[OUT_BITS-1:0];
    endfunction

    // Queue the samples of one segment; closes marks the final beat of the point
    task automatic sample_segment(input pt_t a, input pt_t b, input pt_t c, input pt_t d,
                                  input logic closes);
        sample_t smp;
        for (int s = 1; s <= SAMPLES; s++)
        begin
            smp.x = spline_value(a.x, b.x, c.x, d.x, s);
            smp.y = spline_value(a.y, b.y, c.y, d.y, s);
            smp.start = 1'b0;
            smp.run_last = closes && (s == SAMPLES);
            expected_samples = {expected_samples, smp};
        end
    endtask

    // Work out the results of one accepted control point and advance history
    task automatic tessellate_point(input ctrl_point_t cp);
        pt_t     cur;
        pt_t     lead_pt;
        sample_t smp;
        cur.x = cp.x[COORD_BITS-1:0];
        cur.y = cp.y[COORD_BITS-1:0];
        if (hist_count == 1)
        begin
            smp.x = OUT_BITS'(hist[2].x);
            smp.y = OUT_BITS'(hist[2].y);
            smp.start = 1'b1;
            smp.run_last = !cp.last;
            expected_samples = {expected_samples, smp};
            if (cp.last)
                sample_segment(hist[2], hist[2], cur, cur, 1'b1);
        end
        else if (hist_count >= 2)
        begin
            // clamp the leading neighbor on the first segment
            lead_pt = (hist_count == 2) ? hist[1] : hist[0];
            sample_segment(lead_pt, hist[1], hist[2], cur, !cp.last);
            if (cp.last)
                sample_segment(hist[1], hist[2], cur, cur, 1'b1);
        end

        if (cp.last)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hist[i].x = '0;
                hist[i].y = '0;
            end
            hist_count = 0;
        end
        else
        begin
            hist[0] = hist[1];
            hist[1] = hist[2];
            hist[2] = cur;
            if (hist_count < 3)
                hist_count++;
        end
    endtask

    function automatic logic [PT_BITS-1:0] rand_coord();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return PT_BITS'($urandom);
    endfunction

    task automatic add_point(input logic [PT_BITS-1:0] x, input logic [PT_BITS-1:0] y,
                             input logic last, input int phase);
        ctrl_point_t cp;
        cp.x = x;
        cp.y = y;
        cp.last = last;
        cp.phase = phase;
        points_to_send = {points_to_send, cp};
    endtask

    // Fill the stimulus with whole curves of random length
    task automatic add_random_curves(input int phase);
        int added;
        int len;
        int pick;
        added = 0;
        while (added < ITEMS_PER_PHASE)
        begin
            pick = $urandom_range(19);
            if (pick == 0)
                len = 1;
            else if (pick == 1)
                len = 2;
            else if (pick == 2)
                len = $urandom_range(11, 20);
            else
                len = $urandom_range(3, 10);
            for (int i = 0; i < len; i++)
                add_point(rand_coord(), rand_coord(), i == len - 1, phase);
            added += len;
        end
    endtask

    function automatic logic idle_roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Driver: present pending points on the push side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            point_x <= '0;
            point_y <= '0;
            last_point <= 1'b0;
        end
        else if (!(push && full))
        begin
            if (push)
            begin
                tessellate_point(points_to_send[0]);
                void'(points_to_send.pop_front());
            end
            if (points_to_send.size() != 0 &&
                !((points_to_send[0].phase == PH_SEND_IDLE && idle_roll(87)) ||
                  (points_to_send[0].phase == PH_BOTH_IDLE && idle_roll(6))))
            begin
                push <= 1'b1;
                point_x <= points_to_send[0].x;
                point_y <= points_to_send[0].y;
                last_point <= points_to_send[0].last;
                cur_phase <= points_to_send[0].phase;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: take result beats and check them against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : monitor
        sample_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected result x=%0d y=%0d start=%0b last=%0b",
                             $time, curve_x, curve_y, path_start, run_last);
                    error_count++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (curve_x !== want.x)
                    begin
                        $display("%0t: curve_x expected %0d got %0d", $time, want.x, curve_x);
                        error_count++;
                    end
                    if (curve_y !== want.y)
                    begin
                        $display("%0t: curve_y expected %0d got %0d", $time, want.y, curve_y);
                        error_count++;
                    end
                    if (path_start !== want.start)
                    begin
                        $display("%0t: path_start expected %0b got %0b",
                                 $time, want.start, path_start);
                        error_count++;
                    end
                    if (run_last !== want.run_last)
                    begin
                        $display("%0t: run_last expected %0b got %0b",
                                 $time, want.run_last, run_last);
                        error_count++;
                    end
                end
            end
            pop <= !((cur_phase == PH_RECV_IDLE && idle_roll(87)) ||
                     (cur_phase == PH_BOTH_IDLE && idle_roll(6)));
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            hist[i].x = '0;
            hist[i].y = '0;
        end

        // Single-point curves emit nothing
        add_point(16'h0000, 16'h0000, 1'b1, PH_STEADY);
        add_point(16'hFFFF, 16'hFFFF, 1'b1, PH_STEADY);
        // Two-point curves: start point plus one clamped segment
        add_point(16'h0000, 16'h0000, 1'b0, PH_STEADY);
        add_point(16'hFFFF, 16'hFFFF, 1'b1, PH_STEADY);
        add_point(16'hFFFF, 16'h0000, 1'b0, PH_STEADY);
        add_point(16'h0000, 16'hFFFF, 1'b1, PH_STEADY);
        // Three points: both ends clamped
        add_point(16'h0000, 16'h0000, 1'b0, PH_STEADY);
        add_point(16'hFFFF, 16'hFFFF, 1'b0, PH_STEADY);
        add_point(16'h0000, 16'h0000, 1'b1, PH_STEADY);
        // Zigzag for the deepest overshoot on both sides
        add_point(16'h0000, 16'hFFFF, 1'b0, PH_STEADY);
        add_point(16'hFFFF, 16'h0000, 1'b0, PH_STEADY);
        add_point(16'h0000, 16'hFFFF, 1'b0, PH_STEADY);
        add_point(16'hFFFF, 16'h0000, 1'b0, PH_STEADY);
        add_point(16'hFFFF, 16'hFFFF, 1'b1, PH_STEADY);
        // Mixed coordinates with a full window
        add_point(16'h8000, 16'h7FFF, 1'b0, PH_STEADY);
        add_point(16'h5555, 16'hAAAA, 1'b0, PH_STEADY);
        add_point(16'h0001, 16'hFFFE, 1'b0, PH_STEADY);
        add_point(16'hFFFE, 16'h0001, 1'b1, PH_STEADY);

        add_random_curves(PH_STEADY);
        add_random_curves(PH_SEND_IDLE);
        add_random_curves(PH_RECV_IDLE);
        add_random_curves(PH_BOTH_IDLE);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (points_to_send.size() == 0 && expected_samples.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_samples.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("%0t: timeout, %0d points unsent, %0d samples outstanding",
                 $time, points_to_send.size(), expected_samples.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
